// ===== hw/rtl/multichannel_moving_average_assert.svh =====
// Assertion macros shared by the moving-average checker.
`ifndef MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH

// Clocked assertion, quiet while reset is held.
`define MMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MMA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mma_pkg.sv =====
// Shared types and constants of the multichannel moving-average filter.
package mma_pkg;

  localparam int unsigned DATA_W      = 12;
  localparam int unsigned CH_W        = 3;
  localparam int unsigned TDATA_W     = 16;
  localparam int unsigned TUSER_IN_W  = 3;
  localparam int unsigned TUSER_OUT_W = 4;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam int unsigned WINDOW_LEN_DEF   = 20;
  localparam int unsigned NUM_CHANNELS_DEF = 5;

  localparam logic [DATA_W-1:0] LOW_FLOOR_RST = 12'd5;
  localparam logic [DATA_W-1:0] FAR_SUB_RST   = 12'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_FLOOR = 1'b0,
    REG_FAR_SUB   = 1'b1
  } cfg_reg_e;

  // Control that travels with a request down the pipeline.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    logic            in_range;
    logic            full;      // window was full before this sample
  } ctl_t;

endpackage

// ===== hw/rtl/mma_ram.sv =====
// Generic single-port-write, registered-read RAM (read returns old data on a collision).
module mma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mma_front.sv =====
// Per-channel slot pointers and fill flags, slot address generation and input register.
module mma_front import mma_pkg::*; #(
  parameter int unsigned WINDOW_LEN   = WINDOW_LEN_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  localparam int unsigned ADDR_W = $clog2(NUM_CHANNELS * WINDOW_LEN)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,        // stage 1 may load
  input  logic              in_valid_i,
  input  logic [CH_W-1:0]   in_ch_i,
  input  logic [DATA_W-1:0] in_sample_i,
  output logic              mem_we_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_addr_o,
  output ctl_t              s1_ctl_o,
  output logic [DATA_W-1:0] s1_sample_o
);

  localparam int unsigned PTR_W  = $clog2(WINDOW_LEN);
  localparam int unsigned CIDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [PTR_W-1:0]  ptr_q [NUM_CHANNELS];
  logic              full_q [NUM_CHANNELS];
  logic [CIDX_W-1:0] ch_idx;
  logic              in_range;
  logic              accept;
  logic [PTR_W-1:0]  ptr_cur;
  logic              wrap;
  ctl_t              s1_ctl_d, s1_ctl_q;
  logic [DATA_W-1:0] s1_sample_q;

  assign ch_idx   = CIDX_W'(in_ch_i);
  assign in_range = int'(in_ch_i) < NUM_CHANNELS;
  assign accept   = in_valid_i && en_i;
  assign ptr_cur  = ptr_q[ch_idx];
  assign wrap     = (ptr_cur == PTR_W'(WINDOW_LEN - 1));

  assign mem_addr_o = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_LEN) + ADDR_W'(ptr_cur);
  assign mem_we_o   = accept && in_range;
  assign mem_re_o   = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        full_q[c] <= 1'b0;
      end
    end else if (accept && in_range) begin
      ptr_q[ch_idx] <= wrap ? '0 : ptr_cur + PTR_W'(1);
      if (wrap) begin
        full_q[ch_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    s1_ctl_d.valid    = in_valid_i;
    s1_ctl_d.ch       = in_ch_i;
    s1_ctl_d.in_range = in_range;
    s1_ctl_d.full     = in_range && full_q[ch_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (en_i) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= in_sample_i;
    end
  end

  assign s1_ctl_o    = s1_ctl_q;
  assign s1_sample_o = s1_sample_q;

endmodule

// ===== hw/rtl/mma_sum.sv =====
// Per-channel running window sums, updated with the evicted sample from the slot store.
module mma_sum import mma_pkg::*; #(
  parameter int unsigned WINDOW_LEN   = WINDOW_LEN_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  localparam int unsigned SUM_W = $clog2((2 ** DATA_W - 1) * WINDOW_LEN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ctl_t              s1_ctl_i,
  input  logic [DATA_W-1:0] s1_sample_i,
  input  logic [DATA_W-1:0] old_sample_i,
  output ctl_t              s2_ctl_o,
  output logic [SUM_W-1:0]  s2_sum_o
);

  localparam int unsigned CIDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [SUM_W-1:0]  sum_q [NUM_CHANNELS];
  logic [CIDX_W-1:0] ch_idx;
  logic [SUM_W-1:0]  evict;
  logic [SUM_W-1:0]  sum_new;
  ctl_t              s2_ctl_q;
  logic [SUM_W-1:0]  s2_sum_q;

  assign ch_idx = CIDX_W'(s1_ctl_i.ch);
  // Slot contents only count once the window has wrapped; before that the slot is unwritten.
  assign evict   = s1_ctl_i.full ? SUM_W'(old_sample_i) : '0;
  assign sum_new = sum_q[ch_idx] + SUM_W'(s1_sample_i) - evict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sum_q[c] <= '0;
      end
    end else if (en_i && s1_ctl_i.valid && s1_ctl_i.in_range) begin
      sum_q[ch_idx] <= sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en_i) begin
      s2_ctl_q <= s1_ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_ctl_i.valid) begin
      s2_sum_q <= sum_new;
    end
  end

  assign s2_ctl_o = s2_ctl_q;
  assign s2_sum_o = s2_sum_q;

endmodule

// ===== hw/rtl/mma_mean.sv =====
// Window mean by reciprocal multiply, floor substitution, config registers and result register.
module mma_mean import mma_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  localparam int unsigned SUM_W = $clog2((2 ** DATA_W - 1) * WINDOW_LEN + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  ctl_t                 s2_ctl_i,
  input  logic [SUM_W-1:0]     s2_sum_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output logic                 out_valid_o,
  output logic [CH_W-1:0]      out_ch_o,
  output logic                 out_ready_o,
  output logic [DATA_W-1:0]    out_filtered_o
);

  // floor(x / W) == (x * RECIP) >> SHIFT for every SUM_W-bit x
  localparam int unsigned LOG_W   = $clog2(WINDOW_LEN);
  localparam int unsigned SHIFT   = SUM_W + LOG_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT) / WINDOW_LEN) + 64'd1);
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;

  logic [DATA_W-1:0] low_floor_q, far_sub_q;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] mean;
  logic              ready;
  logic [DATA_W-1:0] filtered_d;
  logic              out_valid_q;
  logic [CH_W-1:0]   out_ch_q;
  logic              out_ready_q;
  logic [DATA_W-1:0] out_filtered_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_floor_q <= LOW_FLOOR_RST;
      far_sub_q   <= FAR_SUB_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_LOW_FLOOR) begin
        low_floor_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_FAR_SUB) begin
        far_sub_q <= cfg_wdata_i;
      end
    end
  end

  assign prod  = PROD_W'(s2_sum_i) * PROD_W'(RECIP);
  assign mean  = prod[SHIFT +: DATA_W];
  assign ready = s2_ctl_i.in_range && s2_ctl_i.full;

  always_comb begin
    if (!ready) begin
      filtered_d = '0;
    end else if (mean < low_floor_q) begin
      filtered_d = far_sub_q;
    end else begin
      filtered_d = mean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= s2_ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s2_ctl_i.valid) begin
      out_ch_q       <= s2_ctl_i.ch;
      out_ready_q    <= ready;
      out_filtered_q <= filtered_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_ch_o       = out_ch_q;
  assign out_ready_o    = out_ready_q;
  assign out_filtered_o = out_filtered_q;

endmodule

// ===== hw/rtl/multichannel_moving_average.sv =====
// Multichannel boxcar moving-average filter: top level.
// One request per clock sustained while m_axis_tready is high; a result is offered once its
// request has passed three register stages (slot store read, running-sum update, mean and
// floor check), later only while the result register waits on m_axis_tready. Each stage
// holds one request and moves on as soon as the stage after it is free, so input requests
// keep flowing while a result waits, until the three stages are occupied. Every channel
// keeps WINDOW_LEN samples in one shared RAM (one read per request, one write per in-range
// request, old data returned on the same slot). The first WINDOW_LEN samples of a channel
// fill its window and give ready 0 with filtered 0; means start with the sample after that.
// Channel numbers at or above NUM_CHANNELS change no state and return ready 0, filtered 0.
// No clearing pass is needed after reset: a slot is written before it is ever counted.
module multichannel_moving_average import mma_pkg::*; #(
  parameter int unsigned WINDOW_LEN   = WINDOW_LEN_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_W-1:0]     s_axis_tdata,    // [11:0] distance
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,    // [2:0] channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_W-1:0]     m_axis_tdata,    // [11:0] filtered
  output logic [TUSER_OUT_W-1:0] m_axis_tuser,    // [2:0] out_channel, [3] ready_res
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_W-1:0]      cfg_wdata_i
);

  localparam int unsigned DEPTH  = NUM_CHANNELS * WINDOW_LEN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SUM_W  = $clog2((2 ** DATA_W - 1) * WINDOW_LEN + 1);

  logic              en1, en2, en_out;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] old_sample;
  ctl_t              s1_ctl, s2_ctl;
  logic [DATA_W-1:0] s1_sample;
  logic [SUM_W-1:0]  s2_sum;
  logic              out_valid;
  logic [CH_W-1:0]   out_ch;
  logic              out_ready;
  logic [DATA_W-1:0] out_filtered;

  // a stage loads when it is empty or its contents move on
  assign en_out = !out_valid || m_axis_tready;
  assign en2    = !s2_ctl.valid || en_out;
  assign en1    = !s1_ctl.valid || en2;

  assign s_axis_tready = en1;

  mma_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en1),
    .in_valid_i (s_axis_tvalid),
    .in_ch_i    (s_axis_tuser[CH_W-1:0]),
    .in_sample_i(s_axis_tdata[DATA_W-1:0]),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .s1_ctl_o   (s1_ctl),
    .s1_sample_o(s1_sample)
  );

  mma_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_addr),
    .wdata_i(s_axis_tdata[DATA_W-1:0]),
    .re_i   (mem_re),
    .raddr_i(mem_addr),
    .rdata_o(old_sample)
  );

  mma_sum #(
    .WINDOW_LEN  (WINDOW_LEN),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en2),
    .s1_ctl_i    (s1_ctl),
    .s1_sample_i (s1_sample),
    .old_sample_i(old_sample),
    .s2_ctl_o    (s2_ctl),
    .s2_sum_o    (s2_sum)
  );

  mma_mean #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_mean (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en_out),
    .s2_ctl_i      (s2_ctl),
    .s2_sum_i      (s2_sum),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid),
    .out_ch_o      (out_ch),
    .out_ready_o   (out_ready),
    .out_filtered_o(out_filtered)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'(out_filtered);
  assign m_axis_tuser  = {out_ready, out_ch};

endmodule

// ===== hw/rtl/mma_checker.sv =====
// Port-level checker for the moving-average filter, bound to the top level.
`include "multichannel_moving_average_assert.svh"

module mma_checker import mma_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [TDATA_W-1:0]     m_tdata_i,
  input logic [TUSER_OUT_W-1:0] m_tuser_i
);

  // a stalled result holds
  `MMA_ASSERT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i), "result changed while stalled")

  // while a window fills the filtered value is zero
  `MMA_ASSERT(a_not_ready_zero, clk_i, rst_ni, m_tvalid_i && !m_tuser_i[3] |-> m_tdata_i == '0, "filtered nonzero without ready")

  // unknown channels never report a mean
  `MMA_ASSERT(a_bad_ch_not_ready, clk_i, rst_ni, m_tvalid_i && (int'(m_tuser_i[CH_W-1:0]) >= NUM_CHANNELS) |-> !m_tuser_i[3], "ready on unknown channel")

  // an edge under reset leaves no result offered at the next edge
  `MMA_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !m_tvalid_i, "result valid after reset")

endmodule

bind multichannel_moving_average mma_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid),
  .m_tready_i(m_axis_tready),
  .m_tdata_i (m_axis_tdata),
  .m_tuser_i (m_axis_tuser)
);

// ===== tb/tb_multichannel_moving_average.sv =====
// Self-checking testbench for the multichannel moving-average filter.
module tb_multichannel_moving_average;
  import mma_pkg::*;

  localparam int unsigned WIN    = WINDOW_LEN_DEF;
  localparam int unsigned NUM_CH = NUM_CHANNELS_DEF;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              ready;
    logic [DATA_W-1:0] filtered;
  } avg_result_t;

  typedef enum int {DIST_FULL, DIST_LOW, DIST_HIGH} dist_mode_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata  = '0;    // [11:0] distance
  logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;    // [2:0] channel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]     m_axis_tdata;          // [11:0] filtered
  logic [TUSER_OUT_W-1:0] m_axis_tuser;          // [2:0] out_channel, [3] ready_res
  logic                   cfg_we_i      = 1'b0;
  cfg_reg_e               cfg_idx_i     = REG_LOW_FLOOR;
  logic [DATA_W-1:0]      cfg_wdata_i   = '0;

  // predictor state: one window per channel plus the two registers
  logic [DATA_W-1:0] win_samples [NUM_CH][WIN];
  logic [16:0]       win_sum     [NUM_CH];
  int unsigned       win_ptr     [NUM_CH];
  logic              win_full    [NUM_CH];
  logic [DATA_W-1:0] floor_reg = LOW_FLOOR_RST;
  logic [DATA_W-1:0] far_reg   = FAR_SUB_RST;

  avg_result_t pending_results [$];
  bit          idle_en = 1'b1;
  int unsigned mismatch_cnt = 0;
  int unsigned n_checked = 0, n_means = 0, n_subst = 0, n_ignored = 0;

  multichannel_moving_average #(
    .WINDOW_LEN  (WIN),
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Window update for one request; returns the result it should produce.
  function automatic avg_result_t filter_predict(logic [CH_W-1:0] ch, logic [DATA_W-1:0] dist_v);
    avg_result_t r;
    int unsigned c;
    int unsigned p;
    logic [16:0] mean;
    r.ch = ch;
    r.ready = 1'b0;
    r.filtered = '0;
    if (ch >= NUM_CH) return r;
    c = 32'(ch);
    p = win_ptr[c];
    if (!win_full[c]) begin
      win_samples[c][p] = dist_v;
      win_sum[c] = win_sum[c] + 17'(dist_v);
      p++;
      if (p == WIN) begin
        p = 0;
        win_full[c] = 1'b1;
      end
      win_ptr[c] = p;
      return r;
    end
    win_sum[c] = win_sum[c] - 17'(win_samples[c][p]) + 17'(dist_v);
    win_samples[c][p] = dist_v;
    win_ptr[c] = (p + 1 == WIN) ? 0 : p + 1;
    mean = 17'(win_sum[c] / WIN);
    r.ready = 1'b1;
    r.filtered = (mean < 17'(floor_reg)) ? far_reg : mean[DATA_W-1:0];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(logic [CH_W-1:0] ch, logic [DATA_W-1:0] dist_v);
    if (idle_en && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-DATA_W){1'b0}}, dist_v};
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(filter_predict(ch, dist_v));
    @(negedge clk_i);
  endtask

  task automatic wait_drained(int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LOW_FLOOR) floor_reg = val;
    else far_reg = val;
  endtask

  // Mostly in-range channels so windows fill and keep sliding.
  task automatic run_phase(logic [DATA_W-1:0] floor_v, logic [DATA_W-1:0] far_v,
                           dist_mode_e mode, int unsigned n_items, bit idle);
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] dist_v;
    wait_drained(4);
    write_reg(REG_LOW_FLOOR, floor_v);
    write_reg(REG_FAR_SUB, far_v);
    idle_en = idle;
    repeat (n_items) begin
      if ($urandom_range(99) < 10) ch = CH_W'($urandom_range(7, NUM_CH));
      else ch = CH_W'($urandom_range(NUM_CH - 1, 0));
      case (mode)
        DIST_LOW:  dist_v = DATA_W'($urandom_range(12, 0));
        DIST_HIGH: dist_v = DATA_W'($urandom_range(4095, 3900));
        default:   dist_v = DATA_W'($urandom_range(4095, 0));
      endcase
      send_sample(ch, dist_v);
    end
    idle_en = 1'b1;
  endtask

  // Reset register values, unused channel numbers, a full fill and the first mean.
  task automatic test_directed_basics();
    send_sample(3'd7, 12'hFFF);
    send_sample(3'd5, 12'h000);
    send_sample(3'd6, 12'hAAA);
    repeat (WIN - 1) send_sample(3'd0, 12'hFFF);
    send_sample(3'd0, 12'h000);   // fills the last slot, still not ready
    send_sample(3'd0, 12'h000);   // first mean of channel 0
    send_sample(3'd4, 12'h555);
  endtask

  task automatic test_extreme_config();
    run_phase(12'd0, 12'd0, DIST_FULL, 240, 1'b0);   // no idling in this stretch
    run_phase(12'd4095, 12'd4095, DIST_FULL, 235, 1'b1);
    run_phase(12'd4095, 12'd0, DIST_HIGH, 235, 1'b1);
    run_phase(12'd0, 12'd4095, DIST_LOW, 235, 1'b1);
  endtask

  task automatic test_floor_substitution();
    run_phase(LOW_FLOOR_RST, FAR_SUB_RST, DIST_LOW, 235, 1'b1);
    run_phase(DATA_W'($urandom_range(20, 0)), DATA_W'($urandom_range(4095, 0)),
              DIST_LOW, 235, 1'b1);
  endtask

  task automatic test_random_config();
    run_phase(DATA_W'($urandom_range(4095, 0)), DATA_W'($urandom_range(4095, 0)),
              DIST_FULL, 235, 1'b1);
    run_phase(DATA_W'($urandom_range(4095, 3900)), DATA_W'($urandom_range(4095, 0)),
              DIST_HIGH, 235, 1'b1);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !(idle_en && $urandom_range(99) < 9);
  end

  always @(posedge clk_i) begin : result_check
    avg_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result: expected none, actual tuser=%h tdata=%h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.ch >= NUM_CH) n_ignored++;
        if (exp_r.ready) n_means++;
        if (exp_r.ready && exp_r.filtered == far_reg && floor_reg != 0) n_subst++;
        if (m_axis_tuser[CH_W-1:0] !== exp_r.ch) begin
          mismatch_cnt++;
          $display("%0t: out_channel expected %0d actual %0d",
                   $time, exp_r.ch, m_axis_tuser[CH_W-1:0]);
        end
        if (m_axis_tuser[CH_W] !== exp_r.ready) begin
          mismatch_cnt++;
          $display("%0t: ready_res (ch %0d) expected %0b actual %0b",
                   $time, exp_r.ch, exp_r.ready, m_axis_tuser[CH_W]);
        end
        if (m_axis_tdata !== {{(TDATA_W-DATA_W){1'b0}}, exp_r.filtered}) begin
          mismatch_cnt++;
          $display("%0t: filtered (ch %0d) expected %0d actual %0d (tdata %h)",
                   $time, exp_r.ch, exp_r.filtered, m_axis_tdata[DATA_W-1:0], m_axis_tdata);
        end
      end
    end
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      win_sum[c]  = '0;
      win_ptr[c]  = 0;
      win_full[c] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_basics();
    test_extreme_config();
    test_floor_substitution();
    test_random_config();

    wait_drained(12);
    $display("Checked %0d results: %0d window means, %0d likely floor substitutions,",
             n_checked, n_means, n_subst);
    $display("%0d unused-channel requests, register extremes and random settings.", n_ignored);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mma_pkg.sv
hw/rtl/mma_ram.sv
hw/rtl/mma_front.sv
hw/rtl/mma_sum.sv
hw/rtl/mma_mean.sv
hw/rtl/multichannel_moving_average.sv
hw/rtl/mma_checker.sv
tb/tb_multichannel_moving_average.sv
